// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk with synchronous reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check an implication on every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check that a condition holds whenever the enable is high
`define ASSERT_WHEN(label, en, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (en) |-> (cond)) else $error(msg);

`endif

// ===== hw/rtl/mlps_pkg.sv =====
// ----------------------------------------------------------------------------
// mlps_pkg
// Types and constants shared by the LED panel scanner modules.
// ----------------------------------------------------------------------------
package mlps_pkg;

  localparam int SLOT_COUNT  = 8;
  localparam int SLOT_W      = $clog2(SLOT_COUNT);
  localparam int COLUMN_DOTS = 24;
  localparam int OP_W        = 3;
  localparam int DIGIT_W     = 3;
  localparam int SEG_W       = 8;
  localparam int IND_W       = 4;
  localparam int COUNT_W     = 8;
  localparam int ENABLE_W    = 8;
  localparam int DOT_W       = 3 * SEG_W;
  localparam int BLINK_W     = 10;
  localparam int REPEAT_W    = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 10;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_FAST_PERIOD   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOW_PERIOD   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_PERIOD = 2'd2;

  localparam logic [BLINK_W-1:0]  FAST_RESET   = 10'd238;
  localparam logic [BLINK_W-1:0]  SLOW_RESET   = 10'd595;
  localparam logic [REPEAT_W-1:0] REPEAT_RESET = 8'd25;
  localparam logic [SEG_W-1:0]    SEG_RESET    = 8'hFF;

  localparam int IND_SLOT   = 6;
  localparam int COL_A_LOW  = 1;
  localparam int COL_A_MID  = 0;
  localparam int COL_A_HIGH = 4;
  localparam int COL_B_LOW  = 3;
  localparam int COL_B_MID  = 2;
  localparam int COL_B_HIGH = 5;

  typedef enum logic [OP_W-1:0] {
    OP_TICK   = 3'd0,
    OP_DIGIT  = 3'd1,
    OP_BLANK  = 3'd2,
    OP_IND_A  = 3'd3,
    OP_IND_B  = 3'd4,
    OP_COL_A  = 3'd5,
    OP_COL_B  = 3'd6,
    OP_UNUSED = 3'd7
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [DIGIT_W-1:0] slot;
    logic [DOT_W-1:0]   data;
  } cmd_t;

endpackage

// ===== hw/rtl/multiplexed_led_panel_scanner.sv =====
// ----------------------------------------------------------------------------
// multiplexed_led_panel_scanner
// Scans an eight-slot multiplexed LED panel from a shadow and a display store.
//
//   channel  direction  handshake            words
//   in_      input      in_valid/in_ready    tick, digit, blank, indicator, column
//   out_     output     out_valid/out_ready  one per tick, none for writes
//   cfg_     input      cfg_we               blink and repeat periods
//
// One word per cycle unless stalled; a tick is queued, then enters the output register.
// The two-entry command queue sets the input stall: in_ready drops only when it is full.
// Writes drain from the queue while a result waits; a tick waits for the output register.
// Reset is synchronous; both stores come up as all segments lit.
// ----------------------------------------------------------------------------
module multiplexed_led_panel_scanner (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [mlps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mlps_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [mlps_pkg::OP_W-1:0]       in_operation,
  input  logic [mlps_pkg::DIGIT_W-1:0]    in_digit_index,
  input  logic [mlps_pkg::SEG_W-1:0]      in_segment_bits,
  input  logic [mlps_pkg::IND_W-1:0]      in_indicator_bits,
  input  logic [mlps_pkg::COUNT_W-1:0]    in_dot_count,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [mlps_pkg::ENABLE_W-1:0]   out_digit_enable,
  output logic [mlps_pkg::SEG_W-1:0]      out_segments_out,
  output logic                            out_scan_end,
  output logic                            out_repeat_event,
  output logic                            out_fast_toggle_event,
  output logic                            out_slow_toggle_event,
  output logic                            out_fast_level,
  output logic                            out_slow_level
);
  import mlps_pkg::*;

`include "assert_macros.svh"

  logic queue_full;
  logic push;
  cmd_t push_cmd;
  logic head_valid;
  cmd_t head_cmd;
  logic pop;

  mlps_front u_front (
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_operation      (in_operation),
    .in_digit_index    (in_digit_index),
    .in_segment_bits   (in_segment_bits),
    .in_indicator_bits (in_indicator_bits),
    .in_dot_count      (in_dot_count),
    .queue_full        (queue_full),
    .push              (push),
    .push_cmd          (push_cmd)
  );

  mlps_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (queue_full),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop)
  );

  mlps_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata),
    .head_valid            (head_valid),
    .head_cmd              (head_cmd),
    .pop                   (pop),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_digit_enable      (out_digit_enable),
    .out_segments_out      (out_segments_out),
    .out_scan_end          (out_scan_end),
    .out_repeat_event      (out_repeat_event),
    .out_fast_toggle_event (out_fast_toggle_event),
    .out_slow_toggle_event (out_slow_toggle_event),
    .out_fast_level        (out_fast_level),
    .out_slow_level        (out_slow_level)
  );

  `ASSERT_WHEN(a_blank_slot_dark, out_valid && out_scan_end, out_digit_enable == '0, "blank slot enabled")
  `ASSERT_WHEN(a_slot_onehot, out_valid && !out_scan_end, $onehot(out_digit_enable), "enable not one-hot")
  `ASSERT_WHEN(a_events_at_end, out_valid && !out_scan_end, !(out_repeat_event || out_fast_toggle_event || out_slow_toggle_event), "event off scan end")
  `ASSERT_CLK(a_pop_needs_head, pop |-> head_valid, "pop from empty queue")

endmodule

// ===== hw/rtl/mlps_front.sv =====
// ----------------------------------------------------------------------------
// mlps_front
// Accepts input words, drops unused codes and turns each word into a command.
// ----------------------------------------------------------------------------
module mlps_front (
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [mlps_pkg::OP_W-1:0]     in_operation,
  input  logic [mlps_pkg::DIGIT_W-1:0]  in_digit_index,
  input  logic [mlps_pkg::SEG_W-1:0]    in_segment_bits,
  input  logic [mlps_pkg::IND_W-1:0]    in_indicator_bits,
  input  logic [mlps_pkg::COUNT_W-1:0]  in_dot_count,
  input  logic                          queue_full,
  output logic                          push,
  output mlps_pkg::cmd_t                push_cmd
);
  import mlps_pkg::*;

  op_t                op;
  logic [COUNT_W-1:0] lit;
  logic [DOT_W-1:0]   dots;

  assign op       = op_t'(in_operation);
  assign in_ready = !queue_full;
  assign push     = in_valid && !queue_full && (op != OP_UNUSED);

  always_comb begin
    lit = (in_dot_count > COUNT_W'(COLUMN_DOTS)) ? COUNT_W'(COLUMN_DOTS) : in_dot_count;
    for (int i = 0; i < DOT_W; i++) begin
      dots[i] = (COUNT_W'(i) < lit);
    end
  end

  always_comb begin
    push_cmd.op   = op;
    push_cmd.slot = in_digit_index;
    push_cmd.data = '0;
    unique case (op)
      OP_DIGIT:           push_cmd.data = DOT_W'(in_segment_bits);
      OP_IND_A, OP_IND_B: push_cmd.data = DOT_W'(in_indicator_bits);
      OP_COL_A, OP_COL_B: push_cmd.data = dots;
      default:            push_cmd.data = '0;
    endcase
  end

endmodule

// ===== hw/rtl/mlps_queue.sv =====
// ----------------------------------------------------------------------------
// mlps_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module mlps_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  mlps_pkg::cmd_t push_cmd,
  output logic           full,
  output logic           head_valid,
  output mlps_pkg::cmd_t head_cmd,
  input  logic           pop
);
  import mlps_pkg::*;

  cmd_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_pop;

  assign full       = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = mem_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== hw/rtl/mlps_back.sv =====
// ----------------------------------------------------------------------------
// mlps_back
// Executes commands: shadow writes, scan ticks, blink counters, output word.
// ----------------------------------------------------------------------------
module mlps_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [mlps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mlps_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            head_valid,
  input  mlps_pkg::cmd_t                  head_cmd,
  output logic                            pop,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [mlps_pkg::ENABLE_W-1:0]   out_digit_enable,
  output logic [mlps_pkg::SEG_W-1:0]      out_segments_out,
  output logic                            out_scan_end,
  output logic                            out_repeat_event,
  output logic                            out_fast_toggle_event,
  output logic                            out_slow_toggle_event,
  output logic                            out_fast_level,
  output logic                            out_slow_level
);
  import mlps_pkg::*;

  logic [BLINK_W-1:0]  fast_period_r, slow_period_r;
  logic [REPEAT_W-1:0] repeat_period_r;

  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  logic [SEG_W-1:0]    shadow_r [SLOT_COUNT];
  logic [SEG_W-1:0]    shadow_nxt [SLOT_COUNT];
  logic [SEG_W-1:0]    shown_r [SLOT_COUNT];
  logic [SEG_W-1:0]    shown_nxt [SLOT_COUNT];
  logic                pending_r, pending_nxt;
  logic [REPEAT_W-1:0] repeat_cnt_r, repeat_cnt_nxt;
  logic [BLINK_W-1:0]  fast_cnt_r, fast_cnt_nxt;
  logic [BLINK_W-1:0]  slow_cnt_r, slow_cnt_nxt;
  logic                fast_lvl_r, fast_lvl_nxt;
  logic                slow_lvl_r, slow_lvl_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [ENABLE_W-1:0] enable_r, enable_nxt;
  logic [SEG_W-1:0]    seg_r, seg_nxt;
  logic                end_r, end_nxt;
  logic                rep_ev_r, rep_ev_nxt;
  logic                fast_ev_r, fast_ev_nxt;
  logic                slow_ev_r, slow_ev_nxt;
  logic                fast_out_r, fast_out_nxt;
  logic                slow_out_r, slow_out_nxt;

  logic                last;
  logic                rep_hit, fast_hit, slow_hit;

  assign pop = head_valid && ((head_cmd.op != OP_TICK) || !out_valid_r || out_ready);

  assign last     = (slot_r == SLOT_W'(SLOT_COUNT - 1));
  assign rep_hit  = (repeat_cnt_r <= REPEAT_W'(1));
  assign fast_hit = (fast_cnt_r <= BLINK_W'(1));
  assign slow_hit = (slow_cnt_r <= BLINK_W'(1));

  always_comb begin
    slot_nxt       = slot_r;
    shadow_nxt     = shadow_r;
    shown_nxt      = shown_r;
    pending_nxt    = pending_r;
    repeat_cnt_nxt = repeat_cnt_r;
    fast_cnt_nxt   = fast_cnt_r;
    slow_cnt_nxt   = slow_cnt_r;
    fast_lvl_nxt   = fast_lvl_r;
    slow_lvl_nxt   = slow_lvl_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    enable_nxt     = enable_r;
    seg_nxt        = seg_r;
    end_nxt        = end_r;
    rep_ev_nxt     = rep_ev_r;
    fast_ev_nxt    = fast_ev_r;
    slow_ev_nxt    = slow_ev_r;
    fast_out_nxt   = fast_out_r;
    slow_out_nxt   = slow_out_r;
    if (pop) begin
      unique case (head_cmd.op)
        OP_DIGIT: begin
          if (32'(head_cmd.slot) < SLOT_COUNT) begin
            shadow_nxt[SLOT_W'(head_cmd.slot)] = head_cmd.data[SEG_W-1:0];
            pending_nxt = 1'b1;
          end
        end
        OP_BLANK: begin
          for (int i = 0; i < SLOT_COUNT - 1; i++) begin
            shadow_nxt[i] = '0;
          end
          pending_nxt = 1'b1;
        end
        OP_IND_A: begin
          shadow_nxt[IND_SLOT] = {head_cmd.data[IND_W-1:0], shadow_r[IND_SLOT][IND_W-1:0]};
          pending_nxt = 1'b1;
        end
        OP_IND_B: begin
          shadow_nxt[IND_SLOT] = {shadow_r[IND_SLOT][SEG_W-1:IND_W], head_cmd.data[IND_W-1:0]};
          pending_nxt = 1'b1;
        end
        OP_COL_A: begin
          shadow_nxt[COL_A_LOW]  = head_cmd.data[SEG_W-1:0];
          shadow_nxt[COL_A_MID]  = head_cmd.data[2*SEG_W-1:SEG_W];
          shadow_nxt[COL_A_HIGH] = head_cmd.data[3*SEG_W-1:2*SEG_W];
          pending_nxt = 1'b1;
        end
        OP_COL_B: begin
          shadow_nxt[COL_B_LOW]  = head_cmd.data[SEG_W-1:0];
          shadow_nxt[COL_B_MID]  = head_cmd.data[2*SEG_W-1:SEG_W];
          shadow_nxt[COL_B_HIGH] = head_cmd.data[3*SEG_W-1:2*SEG_W];
          pending_nxt = 1'b1;
        end
        OP_TICK: begin
          out_valid_nxt = 1'b1;
          enable_nxt    = last ? '0 : (ENABLE_W'(1) << slot_r);
          seg_nxt       = shown_r[slot_r];
          end_nxt       = last;
          rep_ev_nxt    = last && rep_hit;
          fast_ev_nxt   = last && fast_hit;
          slow_ev_nxt   = last && slow_hit;
          if (last) begin
            repeat_cnt_nxt = rep_hit  ? repeat_period_r : repeat_cnt_r - 1'b1;
            fast_cnt_nxt   = fast_hit ? fast_period_r   : fast_cnt_r - 1'b1;
            slow_cnt_nxt   = slow_hit ? slow_period_r   : slow_cnt_r - 1'b1;
            fast_lvl_nxt   = fast_lvl_r ^ fast_hit;
            slow_lvl_nxt   = slow_lvl_r ^ slow_hit;
            if (pending_r) begin
              shown_nxt   = shadow_r;
              pending_nxt = 1'b0;
            end
            slot_nxt = '0;
          end else begin
            slot_nxt = slot_r + 1'b1;
          end
          fast_out_nxt = fast_lvl_nxt;
          slow_out_nxt = slow_lvl_nxt;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fast_period_r   <= FAST_RESET;
      slow_period_r   <= SLOW_RESET;
      repeat_period_r <= REPEAT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FAST_PERIOD:   fast_period_r   <= cfg_wdata[BLINK_W-1:0];
        CFG_SLOW_PERIOD:   slow_period_r   <= cfg_wdata[BLINK_W-1:0];
        CFG_REPEAT_PERIOD: repeat_period_r <= cfg_wdata[REPEAT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r       <= '0;
      pending_r    <= 1'b1;
      repeat_cnt_r <= REPEAT_RESET;
      fast_cnt_r   <= FAST_RESET;
      slow_cnt_r   <= SLOW_RESET;
      fast_lvl_r   <= 1'b0;
      slow_lvl_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        shadow_r[i] <= SEG_RESET;
        shown_r[i]  <= SEG_RESET;
      end
    end else begin
      slot_r       <= slot_nxt;
      pending_r    <= pending_nxt;
      repeat_cnt_r <= repeat_cnt_nxt;
      fast_cnt_r   <= fast_cnt_nxt;
      slow_cnt_r   <= slow_cnt_nxt;
      fast_lvl_r   <= fast_lvl_nxt;
      slow_lvl_r   <= slow_lvl_nxt;
      out_valid_r  <= out_valid_nxt;
      shadow_r     <= shadow_nxt;
      shown_r      <= shown_nxt;
    end
  end

  always_ff @(posedge clk) begin
    enable_r   <= enable_nxt;
    seg_r      <= seg_nxt;
    end_r      <= end_nxt;
    rep_ev_r   <= rep_ev_nxt;
    fast_ev_r  <= fast_ev_nxt;
    slow_ev_r  <= slow_ev_nxt;
    fast_out_r <= fast_out_nxt;
    slow_out_r <= slow_out_nxt;
  end

  assign out_valid             = out_valid_r;
  assign out_digit_enable      = enable_r;
  assign out_segments_out      = seg_r;
  assign out_scan_end          = end_r;
  assign out_repeat_event      = rep_ev_r;
  assign out_fast_toggle_event = fast_ev_r;
  assign out_slow_toggle_event = slow_ev_r;
  assign out_fast_level        = fast_out_r;
  assign out_slow_level        = slow_out_r;

endmodule
